/* design/utc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types, charset codes and encoding constants of the UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utc_pkg;

  localparam logic [2:0] CS_UTF8    = 3'd0;
  localparam logic [2:0] CS_UTF16LE = 3'd1;
  localparam logic [2:0] CS_UTF16BE = 3'd2;
  localparam logic [2:0] CS_LATIN1  = 3'd3;
  localparam logic [2:0] CS_WIN1252 = 3'd4;

  localparam logic [20:0] REPL_CP      = 21'h00FFFD;
  localparam logic [7:0]  REPL_BYTE    = 8'h3F;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  // One decoded code point on its way from decoder to encoder.
  typedef struct packed {
    logic [20:0] cp;
    logic        run_end;
    logic        text_end;
  } cp_item_t;

  function automatic logic [7:0] win1252_byte(input logic [20:0] cp);
    logic [7:0] b;
    case (cp)
      21'h0020AC: b = 8'h80;
      21'h00201A: b = 8'h82;
      21'h000192: b = 8'h83;
      21'h00201E: b = 8'h84;
      21'h002026: b = 8'h85;
      21'h002020: b = 8'h86;
      21'h002021: b = 8'h87;
      21'h0002C6: b = 8'h88;
      21'h002030: b = 8'h89;
      21'h000160: b = 8'h8A;
      21'h002039: b = 8'h8B;
      21'h000152: b = 8'h8C;
      21'h00017D: b = 8'h8E;
      21'h002018: b = 8'h91;
      21'h002019: b = 8'h92;
      21'h00201C: b = 8'h93;
      21'h00201D: b = 8'h94;
      21'h002022: b = 8'h95;
      21'h002013: b = 8'h96;
      21'h002014: b = 8'h97;
      21'h0002DC: b = 8'h98;
      21'h002122: b = 8'h99;
      21'h000161: b = 8'h9A;
      21'h00203A: b = 8'h9B;
      21'h000153: b = 8'h9C;
      21'h00017E: b = 8'h9E;
      21'h000178: b = 8'h9F;
      default: begin
        if (cp < 21'h000080 || (cp >= 21'h0000A0 && cp <= 21'h0000FF)) begin
          b = cp[7:0];
        end else begin
          b = REPL_BYTE;
        end
      end
    endcase
    return b;
  endfunction

endpackage

/* design/utc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_front
// UTF-8 decoder: buffers an incomplete sequence and emits one code point
// per cycle into the queue while it is not full, replaying bytes after a rejected lead.
// ----------------------------------------------------------------------------
module utc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               q_full,
  output logic               q_push,
  output utc_pkg::cp_item_t  q_item
);

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    if (!b[7]) begin
      n = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  logic [7:0]  w [4];
  logic [2:0]  wn;
  logic        wlast;
  logic        busy;

  logic [31:0] wv;
  logic [31:0] rv;
  logic [31:0] base_v;
  logic [2:0]  base_n;
  logic [2:0]  len;
  logic [2:0]  nlen;
  logic [2:0]  k;
  logic [2:0]  rn;
  logic        need_more;
  logic        park;
  logic        final_emit;
  logic        done;
  logic        accept;
  logic [20:0] cp;
  logic [10:0] v2;
  logic [15:0] v3;
  logic [20:0] v4;
  logic        ok2;
  logic        ok3;
  logic        ok4;

  assign wv        = {w[3], w[2], w[1], w[0]};
  assign len       = lead_len(w[0]);
  assign need_more = (len >= 3'd2) && (len > wn);

  assign v2  = {w[0][4:0], w[1][5:0]};
  assign v3  = {w[0][3:0], w[1][5:0], w[2][5:0]};
  assign v4  = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
  assign ok2 = is_cont(w[1]) && (v2 >= 11'h080);
  assign ok3 = is_cont(w[1]) && is_cont(w[2]) && (v3 >= 16'h0800)
               && (v3[15:11] != 5'b11011);
  assign ok4 = is_cont(w[1]) && is_cont(w[2]) && is_cont(w[3])
               && (v4 >= utc_pkg::SUPP_BASE) && (v4 <= utc_pkg::CP_MAX);

  always_comb begin
    cp = utc_pkg::REPL_CP;
    k  = 3'd1;
    unique case (len)
      3'd1: cp = {13'd0, w[0]};
      3'd2: begin
        if (!need_more && ok2) begin
          cp = {10'd0, v2};
          k  = 3'd2;
        end
      end
      3'd3: begin
        if (!need_more && ok3) begin
          cp = {5'd0, v3};
          k  = 3'd3;
        end
      end
      3'd4: begin
        if (!need_more && ok4) begin
          cp = v4;
          k  = 3'd4;
        end
      end
      default: ;
    endcase
  end

  assign park = need_more && !wlast;
  assign rn   = wn - k;
  assign rv   = wv >> {k, 3'b000};
  assign nlen = lead_len(rv[7:0]);

  // Close the run early when the remaining bytes would only be held back.
  assign final_emit = (rn == 3'd0) || (!wlast && (nlen >= 3'd2) && (nlen > rn));

  assign q_push = busy && !park && !q_full;
  assign done   = busy && (park || (q_push && final_emit));
  assign in_ready = !busy || done;
  assign accept   = in_valid && in_ready;

  assign q_item.cp       = cp;
  assign q_item.run_end  = final_emit;
  assign q_item.text_end = wlast && final_emit;

  assign base_v = (busy && !park) ? rv : wv;
  assign base_n = (busy && !park) ? rn : wn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      wn   <= 3'd0;
    end else if (accept) begin
      busy <= 1'b1;
      wn   <= base_n + 3'd1;
    end else if (done) begin
      busy <= 1'b0;
      wn   <= base_n;
    end else if (q_push) begin
      wn   <= rn;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        w[i] <= (base_n == 3'(i)) ? in_byte : base_v[8*i +: 8];
      end
      wlast <= in_last;
    end else if (done || q_push) begin
      for (int i = 0; i < 4; i++) begin
        w[i] <= base_v[8*i +: 8];
      end
    end
  end

endmodule

/* design/utc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_fifo
// Short queue of decoded code points between decoder and encoder.
// ----------------------------------------------------------------------------
module utc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utc_pkg::cp_item_t  push_item,
  output logic               full,
  output logic               head_valid,
  output utc_pkg::cp_item_t  head,
  input  logic               pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utc_pkg::cp_item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* design/utc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_back
// Charset encoder: turns the queued code point into output bytes, one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module utc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         charset,
  input  logic               head_valid,
  input  utc_pkg::cp_item_t  head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  logic [7:0]  e [4];
  logic [2:0]  n;
  logic [1:0]  idx;
  logic [20:0] s;
  logic [15:0] u0;
  logic [15:0] u1;
  logic [20:0] cp;
  logic        last_b;
  logic        load_ok;

  assign cp = head.cp;
  assign s  = cp - utc_pkg::SUPP_BASE;

  always_comb begin
    if (cp <= 21'h00FFFF) begin
      u0 = cp[15:0];
      u1 = 16'h0000;
    end else begin
      u0 = utc_pkg::HI_SURR_BASE | {6'd0, s[19:10]};
      u1 = utc_pkg::LO_SURR_BASE | {6'd0, s[9:0]};
    end
  end

  always_comb begin
    n    = 3'd0;
    e[0] = 8'h00;
    e[1] = 8'h00;
    e[2] = 8'h00;
    e[3] = 8'h00;
    unique case (charset) inside
      utc_pkg::CS_UTF8: begin
        if (cp < 21'h000080) begin
          n    = 3'd1;
          e[0] = cp[7:0];
        end else if (cp < 21'h000800) begin
          n    = 3'd2;
          e[0] = {3'b110, cp[10:6]};
          e[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h010000) begin
          n    = 3'd3;
          e[0] = {4'b1110, cp[15:12]};
          e[1] = {2'b10, cp[11:6]};
          e[2] = {2'b10, cp[5:0]};
        end else begin
          n    = 3'd4;
          e[0] = {5'b11110, cp[20:18]};
          e[1] = {2'b10, cp[17:12]};
          e[2] = {2'b10, cp[11:6]};
          e[3] = {2'b10, cp[5:0]};
        end
      end
      utc_pkg::CS_UTF16LE, utc_pkg::CS_UTF16BE: begin
        n = (cp <= 21'h00FFFF) ? 3'd2 : 3'd4;
        if (charset == utc_pkg::CS_UTF16BE) begin
          e[0] = u0[15:8];
          e[1] = u0[7:0];
          e[2] = u1[15:8];
          e[3] = u1[7:0];
        end else begin
          e[0] = u0[7:0];
          e[1] = u0[15:8];
          e[2] = u1[7:0];
          e[3] = u1[15:8];
        end
      end
      utc_pkg::CS_LATIN1: begin
        n    = 3'd1;
        e[0] = (cp <= 21'h0000FF) ? cp[7:0] : utc_pkg::REPL_BYTE;
      end
      utc_pkg::CS_WIN1252: begin
        n    = 3'd1;
        e[0] = utc_pkg::win1252_byte(cp);
      end
      default: n = 3'd0;
    endcase
  end

  assign last_b  = ({1'b0, idx} == (n - 3'd1));
  assign load_ok = !m_tvalid || m_tready;
  assign pop     = head_valid && load_ok && ((n == 3'd0) || last_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (load_ok) begin
      m_tvalid <= head_valid && (n != 3'd0);
      if (head_valid && (n != 3'd0)) begin
        idx <= last_b ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && head_valid && (n != 3'd0)) begin
      m_tdata <= e[idx];
      m_tuser <= head.run_end && last_b;
      m_tlast <= head.text_end && last_b;
    end
  end

endmodule

/* design/utf8_to_charset_transcoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_charset_transcoder_core
// UTF-8 byte stream in, text re-encoded in the selected charset out.
// ----------------------------------------------------------------------------
// The decoder takes one input byte per cycle while it is not busy and
// resolves one code point per cycle while the queue is not full (a byte
// that completes no sequence yields none; an item that replays rejected
// bytes yields one code point per byte); the encoder sends one output byte
// per cycle while the output is not stalled, so in steady state the slower
// half sets the pace. A QUEUE_DEPTH deep code point queue lets both halves
// stall on their own. Write cfg_wdata (0 UTF-8, 1 UTF-16LE, 2 UTF-16BE,
// 3 Latin-1, 4 Windows-1252) only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_charset_transcoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // last_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] run_last
  output logic       m_tlast,   // text_end
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata  // target_charset
);

  logic [2:0]        charset;
  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  utc_pkg::cp_item_t q_in;
  utc_pkg::cp_item_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset <= utc_pkg::CS_UTF8;
    end else if (cfg_we) begin
      charset <= cfg_wdata;
    end
  end

  utc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  utc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  utc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .charset    (charset),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

/* design/utc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_checker
// Port-level checks of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module utc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  a_idle_out_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  a_text_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("text end without run end");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
      && $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled output item changed");

endmodule

bind utf8_to_charset_transcoder_core utc_checker u_checker (.*);

/* test/utf8_to_charset_transcoder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_charset_transcoder_core_tb
// Feeds UTF-8 byte streams into the transcoder under every target charset and
// checks each output byte, with its run and text end flags, against a
// behavioral decoder and encoder kept in step with the accepted input. A short
// table covers the extremes and rejection cases, and then random phases of
// mostly well-formed text mixed with noise, truncations and malformed
// sequences follow. Both stream sides stall at random, and the output side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module utf8_to_charset_transcoder_core_tb;

  localparam logic [2:0] CS_SPARE = 3'd5;
  localparam int UNCHECKED = -1;
  localparam int DIR_N = 27;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 38;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_STALL = 400;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [15:0] WIN_HIGH [32] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  localparam logic [2:0] PHASE_CS [PHASES] = '{
    utc_pkg::CS_WIN1252, utc_pkg::CS_UTF8, utc_pkg::CS_UTF16LE, utc_pkg::CS_UTF16BE,
    utc_pkg::CS_LATIN1, CS_SPARE, utc_pkg::CS_UTF8, utc_pkg::CS_UTF16LE
  };

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // Hand-typed output bytes of one item, first byte in the highest used bits.
  typedef struct packed {
    int          n;
    logic [95:0] want;
  } hand_t;

  typedef struct packed {
    logic [2:0]  cs;
    logic [7:0]  data;
    logic        text_last;
    int          n;
    logic [95:0] want;
  } row_t;

  localparam row_t DIR_ROWS [DIR_N] = '{
    '{utc_pkg::CS_UTF8,    8'h00, 1'b0, 1,  96'h00},
    '{utc_pkg::CS_UTF8,    8'hFF, 1'b1, 3,  96'hEFBFBD},
    '{utc_pkg::CS_UTF8,    8'hF4, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'h8F, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'hBF, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'hBF, 1'b0, 4,  96'hF48FBFBF},
    '{utc_pkg::CS_UTF8,    8'hC0, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'h80, 1'b0, 6,  96'hEFBFBD_EFBFBD},
    '{utc_pkg::CS_UTF8,    8'hF7, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'hBF, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'hBF, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'hBF, 1'b1, 12, 96'hEFBFBD_EFBFBD_EFBFBD_EFBFBD},
    '{utc_pkg::CS_UTF8,    8'hED, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'hA0, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF8,    8'h80, 1'b0, 9,  96'hEFBFBD_EFBFBD_EFBFBD},
    '{utc_pkg::CS_UTF16LE, 8'hF0, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF16LE, 8'h9F, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF16LE, 8'h98, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF16LE, 8'h80, 1'b0, 4,  96'h3DD800DE},
    '{utc_pkg::CS_UTF16LE, 8'hE2, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF16BE, 8'h82, 1'b0, 0,  96'h0},
    '{utc_pkg::CS_UTF16BE, 8'hAC, 1'b0, 2,  96'h20AC},
    '{utc_pkg::CS_LATIN1,  8'h80, 1'b1, 1,  96'h3F},
    '{utc_pkg::CS_WIN1252, 8'hE2, 1'b0, UNCHECKED, 96'h0},
    '{utc_pkg::CS_WIN1252, 8'h82, 1'b0, UNCHECKED, 96'h0},
    '{utc_pkg::CS_WIN1252, 8'hAC, 1'b0, 1,  96'h80},
    '{CS_SPARE,            8'h41, 1'b1, 0,  96'h0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_wdata = utc_pkg::CS_UTF8;

  // Decoder and encoder state mirrored from the accepted input.
  logic [7:0] held_bytes [3];
  int         held_cnt = 0;
  logic [2:0] charset_now = utc_pkg::CS_UTF8;

  out_item_t  step_bytes [$];
  out_item_t  out_bytes_q [$];
  hand_t      typed_q [$];
  hand_t      blank_hand = '{n: UNCHECKED, want: '0};

  int         mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit         idle_on = 1'b0;
  bit         long_stall_req = 1'b0;

  utf8_to_charset_transcoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) begin
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  // UTF-8 bytes of a code point, first byte in bits [7:0].
  function automatic void utf8_encode(input logic [20:0] cp, output logic [31:0] seq,
                                      output int len);
    if (cp < 21'h80) begin
      seq = {24'd0, cp[7:0]};
      len = 1;
    end else if (cp < 21'h800) begin
      seq = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      len = 2;
    end else if (cp < utc_pkg::SUPP_BASE) begin
      seq = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      len = 3;
    end else begin
      seq = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
      len = 4;
    end
  endfunction

  function automatic void push_out(input logic [7:0] b);
    out_item_t o;
    o.data = b;
    o.run_last = 1'b0;
    o.text_end = 1'b0;
    step_bytes.insert(step_bytes.size(), o);
  endfunction

  function automatic void put_unit16(input logic [15:0] u);
    if (charset_now == utc_pkg::CS_UTF16BE) begin
      push_out(u[15:8]);
      push_out(u[7:0]);
    end else begin
      push_out(u[7:0]);
      push_out(u[15:8]);
    end
  endfunction

  function automatic logic [7:0] to_cp1252(input logic [20:0] cp);
    int i;
    if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) return cp[7:0];
    for (i = 0; i < 32; i++) begin
      if (WIN_HIGH[i] != 16'h0 && {5'd0, WIN_HIGH[i]} == cp) return 8'h80 + 8'(i);
    end
    return utc_pkg::REPL_BYTE;
  endfunction

  function automatic void encode_point(input logic [20:0] cp);
    logic [31:0] seq;
    logic [20:0] s;
    int          len;
    int          k;
    case (charset_now) inside
      utc_pkg::CS_UTF8: begin
        utf8_encode(cp, seq, len);
        for (k = 0; k < len; k++) push_out(seq[8*k +: 8]);
      end
      utc_pkg::CS_UTF16LE, utc_pkg::CS_UTF16BE: begin
        if (cp < utc_pkg::SUPP_BASE) begin
          put_unit16(cp[15:0]);
        end else begin
          s = cp - utc_pkg::SUPP_BASE;
          put_unit16(utc_pkg::HI_SURR_BASE | {6'd0, s[19:10]});
          put_unit16(utc_pkg::LO_SURR_BASE | {6'd0, s[9:0]});
        end
      end
      utc_pkg::CS_LATIN1: push_out(cp <= 21'hFF ? cp[7:0] : utc_pkg::REPL_BYTE);
      utc_pkg::CS_WIN1252: push_out(to_cp1252(cp));
      default: ;
    endcase
  endfunction

  function automatic int lead_len(input logic [7:0] b);
    if (b[7] == 1'b0) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // Decode one accepted byte together with the held bytes; fill step_bytes.
  function automatic void transcode_item(input logic [7:0] b, input logic text_last);
    logic [7:0]  q [4];
    logic [20:0] cp;
    out_item_t   tail;
    int          qn;
    int          pos;
    int          len;
    int          i;
    bit          ok;
    bit          stop;
    qn = 0;
    pos = 0;
    stop = 1'b0;
    step_bytes.delete();
    for (i = 0; i < held_cnt; i++) q[qn++] = held_bytes[i];
    q[qn++] = b;
    held_cnt = 0;
    while (pos < qn && !stop) begin
      len = lead_len(q[pos]);
      cp = utc_pkg::REPL_CP;
      if (len == 1) begin
        cp = {13'd0, q[pos]};
        pos++;
      end else if (len == 0) begin
        pos++;
      end else if (pos + len > qn) begin
        if (!text_last) begin
          for (i = 0; pos + i < qn; i++) held_bytes[i] = q[pos + i];
          held_cnt = qn - pos;
          stop = 1'b1;
        end else begin
          pos++;
        end
      end else begin
        ok = 1'b1;
        for (i = 1; i < len; i++) begin
          if (q[pos + i][7:6] != 2'b10) ok = 1'b0;
        end
        case (len)
          2: begin
            cp = {10'd0, q[pos][4:0], q[pos + 1][5:0]};
            if (cp < 21'h80) ok = 1'b0;
          end
          3: begin
            cp = {5'd0, q[pos][3:0], q[pos + 1][5:0], q[pos + 2][5:0]};
            if (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF)) ok = 1'b0;
          end
          default: begin
            cp = {q[pos][2:0], q[pos + 1][5:0], q[pos + 2][5:0], q[pos + 3][5:0]};
            if (cp < utc_pkg::SUPP_BASE || cp > utc_pkg::CP_MAX) ok = 1'b0;
          end
        endcase
        if (ok) begin
          pos += len;
        end else begin
          cp = utc_pkg::REPL_CP;
          pos++;
        end
      end
      if (!stop) encode_point(cp);
    end
    if (step_bytes.size() > 0) begin
      tail = step_bytes.pop_back();
      tail.run_last = 1'b1;
      tail.text_end = text_last;
      step_bytes.insert(step_bytes.size(), tail);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t head;
    hand_t     hand;
    int        k;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        hand = typed_q.pop_front();
        transcode_item(s_tdata, s_tlast);
        if (hand.n != UNCHECKED) begin
          if (step_bytes.size() != hand.n) begin
            report_mismatch("table byte count", step_bytes.size(), hand.n);
          end else begin
            for (k = 0; k < hand.n; k++) begin
              if (step_bytes[k].data != hand.want[8*(hand.n-1-k) +: 8]) begin
                report_mismatch("table byte", step_bytes[k].data,
                                hand.want[8*(hand.n-1-k) +: 8]);
              end
            end
          end
        end
        for (k = 0; k < step_bytes.size(); k++) begin
          out_bytes_q.insert(out_bytes_q.size(), step_bytes[k]);
        end
      end
      if (m_tvalid && m_tready) begin
        if (out_bytes_q.size() == 0) begin
          report_mismatch("unexpected out_byte", m_tdata, 0);
        end else begin
          head = out_bytes_q.pop_front();
          if (m_tdata != head.data) report_mismatch("out_byte", m_tdata, head.data);
          if (m_tuser != head.run_last) report_mismatch("run_last", m_tuser, head.run_last);
          if (m_tlast != head.text_end) report_mismatch("text_end", m_tlast, head.text_end);
        end
      end
    end
  end

  // Output side: random stalls, one long hold-off on request.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        m_tready <= 1'b1;
        long_stall_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("utf8_to_charset_transcoder_core_tb failed");
    $finish;
  end

  task automatic send_item(input logic [7:0] data, input logic text_last, input hand_t hand);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    typed_q.insert(typed_q.size(), hand);
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= text_last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, wait out every expected byte, then let the block go quiet.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (out_bytes_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_charset(input logic [2:0] cs);
    cfg_we <= 1'b1;
    cfg_wdata <= cs;
    @(posedge clk);
    cfg_we <= 1'b0;
    charset_now = cs;
  endtask

  // One character of random text: mostly well formed, some noise and damage.
  task automatic send_random_char(output int n_sent);
    logic [31:0] seq;
    logic [20:0] cp;
    int          len;
    int          r;
    int          k;
    bit          end_text;
    r = $urandom_range(0, 99);
    seq = '0;
    len = 1;
    if (r < 74) begin
      if (r < 28) begin
        cp = 21'($urandom_range(0, 'h7F));
      end else if (r < 42) begin
        cp = 21'($urandom_range('h80, 'h7FF));
      end else if (r < 56) begin
        cp = $urandom_range(0, 1) ? 21'($urandom_range('h800, 'hD7FF))
                                  : 21'($urandom_range('hE000, 'hFFFF));
      end else if (r < 66) begin
        cp = 21'($urandom_range('h10000, 'h10FFFF));
      end else begin
        k = $urandom_range(0, 31);
        cp = (WIN_HIGH[k] != 16'h0) ? {5'd0, WIN_HIGH[k]} : 21'(8'h80 + k);
      end
      utf8_encode(cp, seq, len);
    end else if (r < 84) begin
      seq[7:0] = 8'($urandom_range(0, 255));
    end else if (r < 92) begin
      // cut a multibyte sequence short
      cp = 21'($urandom_range('h80, 'h10FFFF));
      utf8_encode(cp, seq, len);
      len = $urandom_range(1, len - 1);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          if ($urandom_range(0, 1)) begin
            seq = {16'd0, 2'b10, 6'($urandom), 7'b1100000, 1'($urandom)};
            len = 2;
          end else begin
            seq = {8'd0, 2'b10, 6'($urandom), 3'b100, 5'($urandom), 8'hE0};
            len = 3;
          end
        end
        1: begin
          seq = {8'd0, 2'b10, 6'($urandom), 3'b101, 5'($urandom), 8'hED};
          len = 3;
        end
        2: begin
          seq = {2'b10, 6'($urandom), 2'b10, 6'($urandom), 2'b10, 6'($urandom),
                 8'($urandom_range('hF4, 'hF7))};
          len = 4;
        end
        default: begin
          seq = {16'd0, 8'($urandom_range(0, 1) ? $urandom_range(0, 'h7F)
                                               : $urandom_range('hC0, 'hFF)),
                 8'($urandom_range('hC2, 'hF4))};
          len = 2;
        end
      endcase
    end
    end_text = ($urandom_range(0, 9) == 0);
    for (k = 0; k < len; k++) begin
      send_item(seq[8*k +: 8], end_text && (k == len - 1), blank_hand);
    end
    n_sent = len;
  endtask

  initial begin
    hand_t      hand;
    logic [2:0] cs;
    int         i;
    int         ph;
    int         sent;
    int         n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;
    for (i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].cs != charset_now) begin
        settle_block();
        write_charset(DIR_ROWS[i].cs);
      end
      hand.n = DIR_ROWS[i].n;
      hand.want = DIR_ROWS[i].want;
      send_item(DIR_ROWS[i].data, DIR_ROWS[i].text_last, hand);
    end
    for (ph = 0; ph < PHASES; ph++) begin
      settle_block();
      cs = (ph == 6) ? 3'($urandom_range(0, 4)) : PHASE_CS[ph];
      write_charset(cs);
      idle_on = (ph != PHASES - 1);
      if (ph == 1) long_stall_req = 1'b1;
      sent = 0;
      while (sent < ((cs == CS_SPARE) ? 12 : PHASE_ITEMS)) begin
        send_random_char(n);
        sent += n;
      end
    end
    settle_block();
    if (mismatch_cnt == 0) begin
      $display("utf8_to_charset_transcoder_core_tb passed");
    end else begin
      $display("utf8_to_charset_transcoder_core_tb failed");
    end
    $finish;
  end

endmodule
